@@ rtl/osptt_pkg.sv @@
package osptt_pkg;

  typedef logic [1:0] action_t;
  typedef logic [1:0] trig_kind_t;
  typedef logic [1:0] add_status_t;
  typedef logic       result_kind_t;

  localparam action_t ACT_ADD     = 2'd0;
  localparam action_t ACT_CLEAR   = 2'd1;
  localparam action_t ACT_REARM   = 2'd2;
  localparam action_t ACT_PROCESS = 2'd3;

  localparam trig_kind_t KIND_TIME_START = 2'd0;
  localparam trig_kind_t KIND_TIME_END   = 2'd1;
  localparam trig_kind_t KIND_DIST_START = 2'd2;
  localparam trig_kind_t KIND_DIST_END   = 2'd3;

  localparam add_status_t ADD_OK       = 2'd0;
  localparam add_status_t ADD_NEGATIVE = 2'd1;
  localparam add_status_t ADD_FULL     = 2'd2;

  localparam result_kind_t RES_ADD_ACK = 1'b0;
  localparam result_kind_t RES_PROCESS = 1'b1;

  localparam int unsigned IDX_OUT_W = 4;

endpackage

@@ rtl/one_shot_progress_trigger_table.sv @@
// one-shot progress trigger table
// input channel: item_valid / item_stall carry one beat per command (add, clear,
// rearm, process). item_stall is high during reset and whenever the sequencer is busy.
// output channel: result_valid / result_stall carry result beats from a single
// output register; a beat is taken when result_valid is high and result_stall low.
// add: after acceptance the ACK state loads the acknowledgement beat once the output register is free.
// clear and rearm: no result beat, done in the accept cycle.
// process: entries are scanned one at a time through the shared comparator,
// each stored entry passing through the READ and CMP states; each fired entry
// after the first also passes through PUSH, and PUSH and FINAL wait while the output
// is stalled. Fired entries come out in index order; the final beat carries last.
// With nothing fired one empty report goes out.
// a held fired index is only pushed once the output register is free, so stalling
// the receiver simply freezes the scan without losing or repeating beats.
// reset (rst, synchronous, active high) empties the table and drops any beat
// waiting in the output register; the table contents are not cleared.
module one_shot_progress_trigger_table #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  osptt_pkg::action_t             action,
  input  osptt_pkg::trig_kind_t          trigger_kind,
  input  logic signed [31:0]             threshold,
  input  logic signed [31:0]             elapsed_time,
  input  logic signed [31:0]             total_time,
  input  logic signed [31:0]             travelled_distance,
  input  logic signed [31:0]             total_distance,
  output logic                           result_valid,
  input  logic                           result_stall,
  output osptt_pkg::result_kind_t        result_kind,
  output osptt_pkg::add_status_t         add_status,
  output logic                           fired,
  output logic [osptt_pkg::IDX_OUT_W-1:0] entry_index,
  output logic                           last
);
  import osptt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACK   = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;
  localparam logic [2:0] S_FINAL = 3'd5;

  logic [2:0]            state;
  logic [CNT_W-1:0]      entry_count;
  logic [33:0]           entry_mem [ENTRIES];
  logic [ENTRIES-1:0]    done;

  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      pend_idx;
  logic                  has_pend;
  add_status_t           ack_status;
  logic [IDX_W-1:0]      ack_index;

  logic signed [32:0]    et_op;
  logic signed [32:0]    tl_op;
  logic signed [32:0]    td_op;
  logic signed [32:0]    dl_op;

  trig_kind_t            rd_kind;
  logic signed [31:0]    rd_thr;

  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic                  at_end;
  logic signed [32:0]    cmp_a;
  logic signed [33:0]    cmp_diff;
  logic                  cmp_hit;
  logic                  hit;
  logic                  full;

  assign item_stall = rst || (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign out_load   = out_free && (state inside {S_ACK, S_PUSH, S_FINAL});
  assign at_end     = ((CNT_W'(idx) + CNT_W'(1)) == entry_count);
  assign full       = (entry_count == CNT_W'(ENTRIES));

  // shared comparator
  always_comb begin
    case (rd_kind)
      KIND_TIME_START: cmp_a = et_op;
      KIND_TIME_END:   cmp_a = tl_op;
      KIND_DIST_START: cmp_a = td_op;
      default:         cmp_a = dl_op;
    endcase
    cmp_diff = 34'(cmp_a) - 34'(rd_thr);
    if (rd_kind == KIND_TIME_END || rd_kind == KIND_DIST_END) begin
      cmp_hit = cmp_diff[33] || (cmp_diff == '0);
    end else begin
      cmp_hit = !cmp_diff[33];
    end
    hit = cmp_hit && !done[idx];
  end

  always_ff @(posedge clk) begin
    if (accept && action == ACT_ADD && !threshold[31] && !full) begin
      entry_mem[entry_count[IDX_W-1:0]] <= {trigger_kind, threshold};
    end
    if (state == S_READ) begin
      {rd_kind, rd_thr} <= entry_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && action == ACT_ADD && !threshold[31] && !full) begin
      done[entry_count[IDX_W-1:0]] <= 1'b0;
    end else if (accept && action == ACT_REARM) begin
      done <= '0;
    end else if (state == S_CMP && hit) begin
      done[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && action == ACT_PROCESS) begin
      et_op <= 33'(elapsed_time);
      td_op <= 33'(travelled_distance);
      tl_op <= 33'(total_time) - 33'(elapsed_time);
      dl_op <= 33'(total_distance) - 33'(travelled_distance);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      result_valid <= 1'b0;
      has_pend     <= 1'b0;
      idx          <= '0;
      pend_idx     <= '0;
      ack_status   <= ADD_OK;
      ack_index    <= '0;
      result_kind  <= RES_ADD_ACK;
      add_status   <= ADD_OK;
      fired        <= 1'b0;
      entry_index  <= '0;
      last         <= 1'b0;
    end else begin
      if (result_valid && !result_stall && !out_load) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (action)
              ACT_ADD: begin
                ack_index <= '0;
                if (threshold[31]) begin
                  ack_status <= ADD_NEGATIVE;
                end else if (full) begin
                  ack_status <= ADD_FULL;
                end else begin
                  ack_status  <= ADD_OK;
                  ack_index   <= entry_count[IDX_W-1:0];
                  entry_count <= entry_count + CNT_W'(1);
                end
                state <= S_ACK;
              end
              ACT_CLEAR: begin
                entry_count <= '0;
              end
              ACT_REARM: begin
              end
              default: begin
                idx      <= '0;
                has_pend <= 1'b0;
                state    <= (entry_count == '0) ? S_FINAL : S_READ;
              end
            endcase
          end
        end
        S_ACK: begin
          if (out_free) begin
            result_valid <= 1'b1;
            result_kind  <= RES_ADD_ACK;
            add_status   <= ack_status;
            fired        <= 1'b0;
            entry_index  <= 4'(ack_index);
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (hit && has_pend) begin
            state <= S_PUSH;
          end else begin
            if (hit) begin
              pend_idx <= idx;
              has_pend <= 1'b1;
            end
            if (at_end) begin
              state <= S_FINAL;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_READ;
            end
          end
        end
        S_PUSH: begin
          if (out_free) begin
            result_valid <= 1'b1;
            result_kind  <= RES_PROCESS;
            add_status   <= ADD_OK;
            fired        <= 1'b1;
            entry_index  <= 4'(pend_idx);
            last         <= 1'b0;
            pend_idx     <= idx;
            if (at_end) begin
              state <= S_FINAL;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_READ;
            end
          end
        end
        S_FINAL: begin
          if (out_free) begin
            result_valid <= 1'b1;
            result_kind  <= RES_PROCESS;
            add_status   <= ADD_OK;
            fired        <= has_pend;
            entry_index  <= has_pend ? 4'(pend_idx) : 4'd0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/one_shot_progress_trigger_table_test.sv @@
module one_shot_progress_trigger_table_test;
  import osptt_pkg::*;

  localparam int TABLE_DEPTH = 16;

  typedef struct {
    action_t     act;
    trig_kind_t  kind;
    logic [31:0] thr;
    logic [31:0] et;
    logic [31:0] tt;
    logic [31:0] td;
    logic [31:0] dt;
  } cmd_t;

  typedef struct {
    result_kind_t         rkind;
    add_status_t          status;
    logic                 hit;
    logic [IDX_OUT_W-1:0] idx;
    logic                 fin;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  action_t action = ACT_ADD;
  trig_kind_t trigger_kind = KIND_TIME_START;
  logic signed [31:0] threshold = '0;
  logic signed [31:0] elapsed_time = '0;
  logic signed [31:0] total_time = '0;
  logic signed [31:0] travelled_distance = '0;
  logic signed [31:0] total_distance = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_kind_t result_kind;
  add_status_t add_status;
  logic fired;
  logic [IDX_OUT_W-1:0] entry_index;
  logic last;

  one_shot_progress_trigger_table #(.ENTRIES(TABLE_DEPTH)) u_dut (.*);

  cmd_t queued_cmds[$];
  report_t pending_reports[$];
  int mismatch_count = 0;

  // predictor copy of the trigger table
  int trig_count = 0;
  trig_kind_t trig_kind[TABLE_DEPTH];
  logic signed [31:0] trig_thr[TABLE_DEPTH];
  logic trig_done[TABLE_DEPTH];

  logic item_taken = 1'b0;
  int unsigned item_gap = 0;
  int unsigned calm_items = 0;
  int unsigned stall_left = 0;
  int unsigned calm_cycles = 0;
  int unsigned stall_roll;
  cmd_t next_cmd;
  report_t want_rep;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic note_mismatch(string text);
    $display("mismatch at %0t: %s", $realtime, text);
    mismatch_count++;
  endtask

  task automatic push_cmd(action_t a, trig_kind_t k, logic [31:0] thr, logic [31:0] et,
                          logic [31:0] tt, logic [31:0] td, logic [31:0] dt);
    cmd_t c;
    c.act = a;
    c.kind = k;
    c.thr = thr;
    c.et = et;
    c.tt = tt;
    c.td = td;
    c.dt = dt;
    queued_cmds.insert(queued_cmds.size(), c);
  endtask

  task automatic predict_trigger_reports();
    logic signed [32:0] time_left;
    logic signed [32:0] dist_left;
    logic signed [32:0] limit;
    logic hit;
    int n;
    report_t rep;
    rep.rkind = RES_ADD_ACK;
    rep.status = ADD_OK;
    rep.hit = 1'b0;
    rep.idx = '0;
    rep.fin = 1'b1;
    case (action)
      ACT_ADD: begin
        if (threshold[31]) begin
          rep.status = ADD_NEGATIVE;
        end else if (trig_count >= TABLE_DEPTH) begin
          rep.status = ADD_FULL;
        end else begin
          trig_kind[trig_count] = trigger_kind;
          trig_thr[trig_count] = threshold;
          trig_done[trig_count] = 1'b0;
          rep.idx = IDX_OUT_W'(trig_count);
          trig_count++;
        end
        pending_reports.insert(pending_reports.size(), rep);
      end
      ACT_CLEAR: trig_count = 0;
      ACT_REARM: begin
        for (int i = 0; i < trig_count; i++) trig_done[i] = 1'b0;
      end
      default: begin
        time_left = $signed({total_time[31], total_time})
                  - $signed({elapsed_time[31], elapsed_time});
        dist_left = $signed({total_distance[31], total_distance})
                  - $signed({travelled_distance[31], travelled_distance});
        n = 0;
        rep.rkind = RES_PROCESS;
        for (int i = 0; i < trig_count; i++) begin
          if (!trig_done[i]) begin
            limit = $signed({trig_thr[i][31], trig_thr[i]});
            case (trig_kind[i])
              KIND_TIME_START: hit = elapsed_time >= trig_thr[i];
              KIND_TIME_END:   hit = time_left <= limit;
              KIND_DIST_START: hit = travelled_distance >= trig_thr[i];
              default:         hit = dist_left <= limit;
            endcase
            if (hit) begin
              trig_done[i] = 1'b1;
              rep.hit = 1'b1;
              rep.idx = IDX_OUT_W'(i);
              rep.fin = 1'b0;
              pending_reports.insert(pending_reports.size(), rep);
              n++;
            end
          end
        end
        if (n == 0) pending_reports.insert(pending_reports.size(), rep);
        else pending_reports[pending_reports.size() - 1].fin = 1'b1;
      end
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // input beat driver
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (item_gap > 0) begin
        item_valid <= 1'b0;
        item_gap <= item_gap - 1;
      end else if (queued_cmds.size() > 0) begin
        next_cmd = queued_cmds.pop_front();
        item_valid <= 1'b1;
        action <= next_cmd.act;
        trigger_kind <= next_cmd.kind;
        threshold <= next_cmd.thr;
        elapsed_time <= next_cmd.et;
        total_time <= next_cmd.tt;
        travelled_distance <= next_cmd.td;
        total_distance <= next_cmd.dt;
        if (calm_items > 0) begin
          calm_items <= calm_items - 1;
          item_gap <= 0;
        end else if ($urandom_range(0, 15) == 0) begin
          calm_items <= 30;
          item_gap <= 0;
        end else begin
          item_gap <= pick_gap();
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result stall driver
  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (calm_cycles > 0) begin
      result_stall <= 1'b0;
      calm_cycles <= calm_cycles - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 3) begin
        result_stall <= 1'b0;
        calm_cycles <= 40;
      end else if (stall_roll < 60) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b1;
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end
    end
  end

  // monitor: predict on accepted input beats, check accepted result beats
  always @(posedge clk) begin
    item_taken <= !rst && item_valid && !item_stall;
    if (rst) begin
      trig_count = 0;
    end else begin
      if (item_valid && !item_stall) predict_trigger_reports();
      if (result_valid && !result_stall) begin
        if (pending_reports.size() == 0) begin
          note_mismatch("result beat with nothing expected");
        end else begin
          want_rep = pending_reports.pop_front();
          if (result_kind !== want_rep.rkind)
            note_mismatch($sformatf("result_kind %0d, wanted %0d", result_kind, want_rep.rkind));
          if (add_status !== want_rep.status)
            note_mismatch($sformatf("add_status %0d, wanted %0d", add_status, want_rep.status));
          if (fired !== want_rep.hit)
            note_mismatch($sformatf("fired %0d, wanted %0d", fired, want_rep.hit));
          if (entry_index !== want_rep.idx)
            note_mismatch($sformatf("entry_index %0d, wanted %0d", entry_index, want_rep.idx));
          if (last !== want_rep.fin)
            note_mismatch($sformatf("last %0d, wanted %0d", last, want_rep.fin));
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("[one_shot_progress_trigger_table] ERROR");
    $finish;
  end

  initial begin
    int gen_count;
    int roll;
    logic [31:0] thr;
    trig_kind_t k;

    // directed beats
    push_cmd(ACT_PROCESS, 2'($urandom()), $urandom(), 32'h0, 32'h0, 32'h0, 32'h0);
    push_cmd(ACT_ADD, KIND_TIME_START, 32'h0, $urandom(), $urandom(), $urandom(), $urandom());
    push_cmd(ACT_ADD, KIND_TIME_END, 32'h7fffffff, $urandom(), $urandom(), $urandom(),
             $urandom());
    push_cmd(ACT_ADD, KIND_DIST_START, 32'h1, $urandom(), $urandom(), $urandom(), $urandom());
    push_cmd(ACT_ADD, KIND_DIST_END, 32'h0, $urandom(), $urandom(), $urandom(), $urandom());
    push_cmd(ACT_ADD, KIND_TIME_START, 32'hffffffff, $urandom(), $urandom(), $urandom(),
             $urandom());
    push_cmd(ACT_ADD, KIND_DIST_START, 32'h80000000, $urandom(), $urandom(), $urandom(),
             $urandom());
    push_cmd(ACT_PROCESS, 2'($urandom()), $urandom(),
             32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    push_cmd(ACT_PROCESS, 2'($urandom()), $urandom(),
             32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    push_cmd(ACT_PROCESS, 2'($urandom()), $urandom(),
             32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    push_cmd(ACT_REARM, 2'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom());
    // every entry exactly at its threshold
    push_cmd(ACT_PROCESS, 2'($urandom()), $urandom(), 32'h0, 32'h7fffffff, 32'h1, 32'h1);
    push_cmd(ACT_CLEAR, 2'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom());
    push_cmd(ACT_PROCESS, 2'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom());
    for (int i = 0; i < TABLE_DEPTH; i++)
      push_cmd(ACT_ADD, trig_kind_t'(i % 4), $urandom() & 32'h7fffffff, $urandom(),
               $urandom(), $urandom(), $urandom());
    push_cmd(ACT_ADD, KIND_TIME_END, 32'h5, $urandom(), $urandom(), $urandom(), $urandom());
    // negative threshold wins over a full table
    push_cmd(ACT_ADD, KIND_DIST_END, 32'h80000001, $urandom(), $urandom(), $urandom(),
             $urandom());
    push_cmd(ACT_PROCESS, 2'($urandom()), $urandom(),
             32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    gen_count = TABLE_DEPTH;

    // random beats
    for (int n = 0; n < 220; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 7) begin
        push_cmd(ACT_CLEAR, 2'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom());
        gen_count = 0;
      end else if (roll < 13) begin
        push_cmd(ACT_REARM, 2'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom());
      end else if (roll < 45) begin
        if (gen_count >= TABLE_DEPTH && $urandom_range(0, 3) != 0) begin
          push_cmd(ACT_CLEAR, 2'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom());
          gen_count = 0;
        end
        roll = $urandom_range(0, 9);
        if (roll == 0) thr = $urandom() | 32'h80000000;
        else if (roll == 1) thr = $urandom() & 32'h7fffffff;
        else thr = $urandom_range(0, 32'h000a0000);
        k = trig_kind_t'($urandom_range(0, 3));
        push_cmd(ACT_ADD, k, thr, $urandom(), $urandom(), $urandom(), $urandom());
        if (!thr[31] && gen_count < TABLE_DEPTH) gen_count++;
      end else begin
        if ($urandom_range(0, 6) == 0)
          push_cmd(ACT_PROCESS, 2'($urandom()), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom());
        else
          push_cmd(ACT_PROCESS, 2'($urandom()), $urandom(),
                   $urandom_range(0, 32'h000c0000) - 32'h00010000,
                   $urandom_range(0, 32'h000c0000) - 32'h00010000,
                   $urandom_range(0, 32'h000c0000) - 32'h00010000,
                   $urandom_range(0, 32'h000c0000) - 32'h00010000);
        if ($urandom_range(0, 4) == 0)
          push_cmd(ACT_REARM, 2'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom());
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (queued_cmds.size() == 0);
    @(posedge clk);
    wait (!item_valid);
    wait (pending_reports.size() == 0);
    repeat (80) @(posedge clk);
    if (pending_reports.size() != 0)
      note_mismatch($sformatf("%0d result beats never arrived", pending_reports.size()));
    if (mismatch_count == 0) begin
      $display("[one_shot_progress_trigger_table] OK");
    end else begin
      $display("[one_shot_progress_trigger_table] ERROR");
    end
    $finish;
  end

endmodule
